// File: sv/dlsq_pkg.sv
// dlsq_pkg: sizes, result codes, entry type and ring address helper
// shared by the sleep queue modules; no dependencies
package dlsq_pkg;

  localparam int unsigned MAX_SLEEPERS = 16;
  localparam int unsigned MAX_RESULTS  = 16;

  localparam int unsigned THREAD_W = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned EV_W     = 2;

  localparam int unsigned IDX_W = $clog2(MAX_SLEEPERS);
  localparam int unsigned CNT_W = $clog2(MAX_SLEEPERS + 1);
  localparam int unsigned NRES_W = $clog2(MAX_RESULTS + 1);

  localparam logic KIND_SLEEP = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam logic [EV_W-1:0] EV_INSERTED = 2'd0;
  localparam logic [EV_W-1:0] EV_ZERO     = 2'd1;
  localparam logic [EV_W-1:0] EV_FULL     = 2'd2;
  localparam logic [EV_W-1:0] EV_WOKEN    = 2'd3;

  typedef struct packed {
    logic [THREAD_W-1:0] thread;
    logic [TIME_W-1:0]   delta;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // logical position to physical slot of the ring
  function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W+1)'(MAX_SLEEPERS)) begin
      sum = sum - (IDX_W+1)'(MAX_SLEEPERS);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// File: sv/dlsq_if.sv
// dlsq_req_if, dlsq_rsp_if: valid/ready channels of the sleep queue
// depends on dlsq_pkg for field widths
interface dlsq_req_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [dlsq_pkg::THREAD_W-1:0] thread_id;
  logic [dlsq_pkg::TIME_W-1:0]   sleep_time;

  modport source (output valid, kind, thread_id, sleep_time, input ready);
  modport sink (input valid, kind, thread_id, sleep_time, output ready);
endinterface

interface dlsq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [dlsq_pkg::EV_W-1:0]     event_res;
  logic [dlsq_pkg::THREAD_W-1:0] woken_id;
  logic                          last;

  modport source (output valid, event_res, woken_id, last, input ready);
  modport sink (input valid, event_res, woken_id, last, output ready);
endinterface

// File: sv/delta_list_sleep_queue.sv
// delta_list_sleep_queue: delta list sleep queue in a ring ram, uses dlsq_pkg/if/ram/alu
// sleep: a zero time or a full queue is rejected at once; else the entries are walked (compare, subtract),
// then the new entry is appended, or the later entries are shifted up (read, write) before the insert
// tick: nothing on an empty queue; else the head delta is decremented, or woken threads are popped, one result each
// one item at a time, accepted again only in the idle state; a stalled output holds the queue in the emit state
// reset clears the entry count, head pointer and output valid; ram contents stay undefined
module delta_list_sleep_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  dlsq_req_if.sink          req_i,
  dlsq_rsp_if.source        rsp_o
);
  import dlsq_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CMP     = 4'd1;
  localparam logic [3:0] S_SUB     = 4'd2;
  localparam logic [3:0] S_SH_RD   = 4'd3;
  localparam logic [3:0] S_SH_WR   = 4'd4;
  localparam logic [3:0] S_INS     = 4'd5;
  localparam logic [3:0] S_TK_HEAD = 4'd6;
  localparam logic [3:0] S_POP     = 4'd7;
  localparam logic [3:0] S_TK_CHK  = 4'd8;
  localparam logic [3:0] S_EMIT    = 4'd9;

  logic [3:0]          state_q, state_d, ret_q, ret_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]    head_q, head_d;
  logic [IDX_W-1:0]    j_q, j_d, k_q, k_d, pos_q, pos_d;
  logic [NRES_W-1:0]   n_q, n_d;
  logic [TIME_W-1:0]   rem_q, rem_d, dl_q, dl_d;
  logic [THREAD_W-1:0] id_q, id_d, pend_q, pend_d;
  logic [EV_W-1:0]     res_ev_q, res_ev_d;
  logic [THREAD_W-1:0] res_id_q, res_id_d;
  logic                res_last_q, res_last_d;
  logic                ov_q;
  logic [EV_W-1:0]     out_ev_q;
  logic [THREAD_W-1:0] out_id_q;
  logic                out_last_q;
  logic                emit_load;

  logic                req_fire;
  logic                ram_we;
  logic [IDX_W-1:0]    wr_lidx, rd_lidx;
  entry_t              wr_data, rd_entry;
  logic [TIME_W-1:0]   alu_a, alu_b, alu_diff;
  logic                alu_borrow, alu_zero;
  logic [CNT_W-1:0]    j_next_cnt;

  assign req_fire   = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign j_next_cnt = CNT_W'(j_q) + CNT_W'(1);

  dlsq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SLEEPERS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (phys_addr(head_q, wr_lidx)),
    .wdata_i (wr_data),
    .raddr_i (phys_addr(head_q, rd_lidx)),
    .rdata_o (rd_entry)
  );

  dlsq_alu u_alu (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .diff_o   (alu_diff),
    .borrow_o (alu_borrow),
    .zero_o   (alu_zero)
  );

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    count_d    = count_q;
    head_d     = head_q;
    j_d        = j_q;
    k_d        = k_q;
    pos_d      = pos_q;
    n_d        = n_q;
    rem_d      = rem_q;
    dl_d       = dl_q;
    id_d       = id_q;
    pend_d     = pend_q;
    res_ev_d   = res_ev_q;
    res_id_d   = res_id_q;
    res_last_d = res_last_q;
    ram_we     = 1'b0;
    wr_lidx    = '0;
    wr_data    = rd_entry;
    rd_lidx    = '0;
    alu_a      = rem_q;
    alu_b      = dl_q;
    emit_load  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          if (req_i.kind == KIND_SLEEP) begin
            id_d       = req_i.thread_id;
            rem_d      = req_i.sleep_time;
            j_d        = '0;
            res_id_d   = req_i.thread_id;
            res_last_d = 1'b1;
            ret_d      = S_IDLE;
            if (req_i.sleep_time == '0) begin
              res_ev_d = EV_ZERO;
              state_d  = S_EMIT;
            end else if (count_q == CNT_W'(MAX_SLEEPERS)) begin
              res_ev_d = EV_FULL;
              state_d  = S_EMIT;
            end else if (count_q == '0) begin
              pos_d   = '0;
              state_d = S_INS;
            end else begin
              state_d = S_CMP;
            end
          end else if (count_q != '0) begin
            state_d = S_TK_HEAD;
          end
        end
      end
      S_CMP: begin
        alu_a = rd_entry.delta;
        alu_b = rem_q;
        if (!alu_borrow && !alu_zero) begin
          ram_we        = 1'b1;
          wr_lidx       = j_q;
          wr_data.delta = alu_diff;
          pos_d         = j_q;
          k_d           = count_q[IDX_W-1:0];
          state_d       = S_SH_RD;
        end else begin
          dl_d    = rd_entry.delta;
          state_d = S_SUB;
        end
      end
      S_SUB: begin
        alu_a   = rem_q;
        alu_b   = dl_q;
        rem_d   = alu_diff;
        j_d     = j_q + IDX_W'(1);
        rd_lidx = j_q + IDX_W'(1);
        if (j_next_cnt == count_q) begin
          pos_d   = j_q + IDX_W'(1);
          state_d = S_INS;
        end else begin
          state_d = S_CMP;
        end
      end
      S_SH_RD: begin
        rd_lidx = k_q - IDX_W'(1);
        state_d = S_SH_WR;
      end
      S_SH_WR: begin
        ram_we  = 1'b1;
        wr_lidx = k_q;
        k_d     = k_q - IDX_W'(1);
        if ((k_q - IDX_W'(1)) == pos_q) begin
          state_d = S_INS;
        end else begin
          state_d = S_SH_RD;
        end
      end
      S_INS: begin
        ram_we         = 1'b1;
        wr_lidx        = pos_q;
        wr_data.thread = id_q;
        wr_data.delta  = rem_q;
        count_d        = count_q + CNT_W'(1);
        res_ev_d       = EV_INSERTED;
        res_id_d       = id_q;
        res_last_d     = 1'b1;
        ret_d          = S_IDLE;
        state_d        = S_EMIT;
      end
      S_TK_HEAD: begin
        alu_a = rd_entry.delta;
        alu_b = TIME_W'(1);
        n_d   = '0;
        if (alu_borrow || alu_zero) begin
          pend_d  = rd_entry.thread;
          state_d = S_POP;
        end else begin
          ram_we        = 1'b1;
          wr_lidx       = '0;
          wr_data.delta = alu_diff;
          state_d       = S_IDLE;
        end
      end
      S_POP: begin
        rd_lidx = IDX_W'(1);
        head_d  = phys_addr(head_q, IDX_W'(1));
        count_d = count_q - CNT_W'(1);
        n_d     = n_q + NRES_W'(1);
        if (count_q == CNT_W'(1) || (n_q + NRES_W'(1)) == NRES_W'(MAX_RESULTS)) begin
          res_ev_d   = EV_WOKEN;
          res_id_d   = pend_q;
          res_last_d = 1'b1;
          ret_d      = S_IDLE;
          state_d    = S_EMIT;
        end else begin
          state_d = S_TK_CHK;
        end
      end
      S_TK_CHK: begin
        alu_a      = rd_entry.delta;
        alu_b      = '0;
        res_ev_d   = EV_WOKEN;
        res_id_d   = pend_q;
        res_last_d = !alu_zero;
        pend_d     = rd_entry.thread;
        ret_d      = alu_zero ? S_POP : S_IDLE;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (!ov_q || rsp_o.ready) begin
          emit_load = 1'b1;
          state_d   = ret_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      count_q <= '0;
      head_q  <= '0;
      n_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      count_q <= count_d;
      head_q  <= head_d;
      n_q     <= n_d;
      if (emit_load) begin
        ov_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    j_q        <= j_d;
    k_q        <= k_d;
    pos_q      <= pos_d;
    rem_q      <= rem_d;
    dl_q       <= dl_d;
    id_q       <= id_d;
    pend_q     <= pend_d;
    res_ev_q   <= res_ev_d;
    res_id_q   <= res_id_d;
    res_last_q <= res_last_d;
    if (emit_load) begin
      out_ev_q   <= res_ev_q;
      out_id_q   <= res_id_q;
      out_last_q <= res_last_q;
    end
  end

  assign rsp_o.valid     = ov_q;
  assign rsp_o.event_res = out_ev_q;
  assign rsp_o.woken_id  = out_id_q;
  assign rsp_o.last      = out_last_q;

endmodule

// File: sv/dlsq_ram.sv
// dlsq_ram: generic single write port, single read port ram with registered read
// no dependencies
module dlsq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/dlsq_alu.sv
// dlsq_alu: shared subtractor with borrow and equal flags
// depends on dlsq_pkg
module dlsq_alu (
  input  logic [dlsq_pkg::TIME_W-1:0] a_i,
  input  logic [dlsq_pkg::TIME_W-1:0] b_i,
  output logic [dlsq_pkg::TIME_W-1:0] diff_o,
  output logic                        borrow_o,
  output logic                        zero_o
);
  import dlsq_pkg::*;

  logic [TIME_W:0] full;

  assign full     = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o   = full[TIME_W-1:0];
  assign borrow_o = full[TIME_W];
  assign zero_o   = (full[TIME_W-1:0] == '0);

endmodule

// File: sv/dlsq_checker.sv
// dlsq_checker: port level assertions for delta_list_sleep_queue, bound to the top level
// depends on dlsq_pkg
module dlsq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          in_kind_i,
  input logic [dlsq_pkg::THREAD_W-1:0] in_id_i,
  input logic [dlsq_pkg::TIME_W-1:0]   in_time_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [dlsq_pkg::EV_W-1:0]     out_ev_i,
  input logic [dlsq_pkg::THREAD_W-1:0] out_id_i,
  input logic                          out_last_i
);
  import dlsq_pkg::*;

  logic                in_xfer, out_xfer;
  logic                pend_q, skip_q, zero_q;
  logic [THREAD_W-1:0] sid_q;
  logic                own;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;
  assign own      = pend_q && !skip_q;

  // track the result owed to the last sleep transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      skip_q <= 1'b0;
      zero_q <= 1'b0;
      sid_q  <= '0;
    end else if (in_xfer && in_kind_i == KIND_SLEEP) begin
      pend_q <= 1'b1;
      skip_q <= out_valid_i && !out_ready_i;
      zero_q <= (in_time_i == '0);
      sid_q  <= in_id_i;
    end else if (out_xfer) begin
      if (skip_q) begin
        skip_q <= 1'b0;
      end else begin
        pend_q <= 1'b0;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_ev_i) &&
      $stable(out_id_i) && $stable(out_last_i))
    else $error("result changed while stalled");

  a_sleep_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && own |-> out_last_i && out_id_i == sid_q && out_ev_i != EV_WOKEN)
    else $error("sleep result malformed");

  a_sleep_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && own |-> ((out_ev_i == EV_ZERO) == zero_q))
    else $error("zero delay not reported as such");

  a_woken_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && out_ev_i == EV_WOKEN |-> !own)
    else $error("wake reported for a sleep transfer");

endmodule

bind delta_list_sleep_queue dlsq_checker u_dlsq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .in_kind_i   (req_i.kind),
  .in_id_i     (req_i.thread_id),
  .in_time_i   (req_i.sleep_time),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_ev_i    (rsp_o.event_res),
  .out_id_i    (rsp_o.woken_id),
  .out_last_i  (rsp_o.last)
);
